// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL. In synthesis the macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every rising clock edge outside reset.
`define ABCQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// The boolean condition must never be seen outside reset.
`define ABCQ_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ABCQ_ASSERT(label, clk, rst, prop)
`define ABCQ_NEVER(label, clk, rst, cond)

`endif

`endif

// ===== hw/rtl/abcq_pkg.sv =====
`timescale 1ns / 1ps

package abcq_pkg;

   // One half in Q2.14.
   localparam logic signed [15:0] HALF_Q = 16'sd8192;

   localparam logic [2:0] MODE_BOTH    = 3'd0;
   localparam logic [2:0] MODE_EITHER  = 3'd1;
   localparam logic [2:0] MODE_ONE     = 3'd2;
   localparam logic [2:0] MODE_NEITHER = 3'd3;
   localparam logic [2:0] MODE_GATE    = 3'd4;
   localparam logic [2:0] MODE_BLOCK   = 3'd5;
   localparam logic [2:0] MODE_PRIMARY = 3'd6;

   localparam logic [1:0] CSR_CHORD_MODE   = 2'd0;
   localparam logic [1:0] CSR_REPEAT_DELAY = 2'd1;
   localparam logic [1:0] CSR_TAP_WINDOW   = 2'd2;

   localparam logic [2:0]  RESET_CHORD_MODE   = MODE_PRIMARY;
   localparam logic [15:0] RESET_REPEAT_DELAY = 16'd0;
   localparam logic [15:0] RESET_TAP_WINDOW   = 16'd400;

   localparam int FLAG_PRESSED   = 0;
   localparam int FLAG_TRIGGERED = 1;
   localparam int FLAG_RELEASED  = 2;
   localparam int FLAG_QUICK     = 3;

   typedef struct packed {
      logic signed [15:0] level;
      logic signed [15:0] change;
      logic [3:0]         flags;
      logic [15:0]        hold;
      logic [15:0]        gap;
      logic [7:0]         taps;
   } unit_state_type;

   function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
      logic signed [15:0] r;
      if (v > 18'sd32767) begin
         r = 16'sh7fff;
      end else if (v < -18'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   function automatic logic [15:0] add_sat16(input logic [15:0] a, input logic [9:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {7'd0, b};
      return s[16] ? 16'hffff : s[15:0];
   endfunction

endpackage

// ===== hw/rtl/abcq_unit.sv =====
`timescale 1ns / 1ps

module abcq_unit (
   input  logic [9:0]               el,
   input  logic signed [15:0]       lvl,
   input  logic signed [17:0]       chg,
   input  logic [15:0]              tap_window,
   input  abcq_pkg::unit_state_type cur,
   output abcq_pkg::unit_state_type nxt
);
   import abcq_pkg::*;

   logic signed [15:0] chg_s;
   logic               was;
   logic               pressed;
   logic [15:0]        gap_step;
   logic [15:0]        gap_t;
   logic [7:0]         taps_t;

   always_comb begin
      chg_s   = sat16(chg);
      was     = cur.flags[FLAG_PRESSED];
      pressed = (lvl >= HALF_Q) || (lvl <= -HALF_Q);

      nxt.level  = lvl;
      nxt.change = chg_s;
      nxt.flags[FLAG_QUICK]     = was && cur.flags[FLAG_TRIGGERED] && (chg_s <= -HALF_Q);
      nxt.flags[FLAG_PRESSED]   = pressed;
      nxt.flags[FLAG_TRIGGERED] = chg_s >= HALF_Q;
      nxt.flags[FLAG_RELEASED]  = chg_s < -HALF_Q;

      // Hold time keeps its value on the tick of release.
      if (pressed && was) begin
         nxt.hold = add_sat16(cur.hold, el);
      end else if (!was) begin
         nxt.hold = 16'd0;
      end else begin
         nxt.hold = cur.hold;
      end

      gap_step = add_sat16(cur.gap, el);
      taps_t   = cur.taps;
      gap_t    = cur.gap;
      if (cur.taps != 8'd0) begin
         if (gap_step > tap_window) begin
            taps_t = 8'd0;
            gap_t  = 16'd0;
         end else begin
            gap_t = gap_step;
         end
      end
      if (pressed && !was) begin
         if (gap_t <= tap_window && taps_t != 8'hff) begin
            taps_t = taps_t + 8'd1;
         end
         gap_t = 16'd0;
      end
      nxt.gap  = gap_t;
      nxt.taps = taps_t;
   end

endmodule

// ===== hw/rtl/analog_button_chord_qualifier.sv =====
`timescale 1ns / 1ps
// Analog button chord qualifier.
// Request channel (req_*): one item per tick with the elapsed time and the raw
// level and change of the primary and the modifier control.
// Response channel (rsp_*): one item per request, the combined qualified level,
// change, pressed/triggered/released/quick-release flags, hold time and taps.
// Both channels use valid/ready; an item moves when both are high.
// Configuration (csr_*): index 0 chord mode, 1 repeat delay, 2 tap window; the
// port is always ready; it must be written only while no item is in flight, which
// the block itself does not enforce. An accepted item waits in the input register
// and moves to the response register when that register can advance.
// Throughput: one item per cycle unless stalled; the qualifier state is updated in a single
// pass of compare and add logic between the input and the response register.
// If the receiver stalls, the response register holds and the input register
// still takes an item only if empty; after that req_ready falls until rsp_ready returns.
// Reset clears all qualifier state and the gate latch, sets chord mode to
// primary only, the repeat delay to zero and the tap window to 400 ms.
`include "assert_macros.svh"

module analog_button_chord_qualifier (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [9:0]         req_elapsed_ms,
   input  logic signed [15:0] req_primary_level,
   input  logic signed [15:0] req_primary_change,
   input  logic signed [15:0] req_modifier_level,
   input  logic signed [15:0] req_modifier_change,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_level,
   output logic signed [15:0] rsp_change,
   output logic               rsp_pressed,
   output logic               rsp_triggered,
   output logic               rsp_released,
   output logic               rsp_quick_release,
   output logic [15:0]        rsp_hold_ms,
   output logic [7:0]         rsp_tap_count,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import abcq_pkg::*;

   // Input register
   logic               in_valid_ff, in_valid_in;
   logic [9:0]         el_ff;
   logic signed [15:0] pl_ff, pc_ff, ml_ff, mc_ff;

   // Configuration and qualifier state
   logic [2:0]     chord_mode_ff, chord_mode_in;
   logic [15:0]    repeat_delay_ff, repeat_delay_in;
   logic [15:0]    tap_window_ff, tap_window_in;
   logic [15:0]    repeat_remaining_ff, repeat_remaining_in;
   logic           gate_latch_ff, gate_latch_in;
   unit_state_type pri_ff, pri_in;
   unit_state_type mod_ff, mod_in;
   unit_state_type cmb_ff, cmb_in;

   // Response register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [15:0] rsp_level_ff;
   logic signed [15:0] rsp_change_ff;
   logic [3:0]         rsp_flags_ff;
   logic [15:0]        rsp_hold_ff;
   logic [7:0]         rsp_taps_ff;

   logic adv;
   logic step;
   logic csr_write;

   unit_state_type     pri_nx, mod_nx, cmb_nx;
   logic               pp, mp;
   logic signed [15:0] p, m, cl, mx, mn;
   logic signed [16:0] sel_lvl;
   logic signed [17:0] sel_chg;
   logic               mod_upd;
   logic               latch_nx;
   logic signed [15:0] lvl_s, lvl_r;
   logic signed [17:0] chg_r;
   logic [15:0]        rem_nx;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && adv;
   assign req_ready = !in_valid_ff || adv;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   abcq_unit u_pri (
      .el         (el_ff),
      .lvl        (pl_ff),
      .chg        (18'(pc_ff)),
      .tap_window (tap_window_ff),
      .cur        (pri_ff),
      .nxt        (pri_nx)
   );

   abcq_unit u_mod (
      .el         (el_ff),
      .lvl        (ml_ff),
      .chg        (18'(mc_ff)),
      .tap_window (tap_window_ff),
      .cur        (mod_ff),
      .nxt        (mod_nx)
   );

   // Chord selection: level and change offered to the combined unit.
   always_comb begin
      pp       = pri_nx.flags[FLAG_PRESSED];
      mp       = mod_nx.flags[FLAG_PRESSED];
      p        = pri_nx.level;
      m        = mod_nx.level;
      cl       = cmb_ff.level;
      mx       = (p >= m) ? p : m;
      mn       = (p <= m) ? p : m;
      sel_lvl  = 17'(p);
      sel_chg  = 18'(pri_nx.change);
      mod_upd  = 1'b0;
      latch_nx = gate_latch_ff;
      if (chord_mode_ff >= MODE_PRIMARY) begin
         sel_lvl = 17'(p);
         sel_chg = 18'(pri_nx.change);
      end else if (gate_latch_ff && pp) begin
         // The latch mutes everything while the primary stays down.
         sel_lvl = 17'sd0;
         sel_chg = 18'sd0;
      end else begin
         mod_upd  = 1'b1;
         latch_nx = 1'b0;
         case (chord_mode_ff)
            MODE_BOTH, MODE_EITHER, MODE_ONE: begin
               sel_lvl = 17'(mx);
               if (chord_mode_ff == MODE_BOTH && !(pp && mp)) begin
                  sel_lvl = 17'sd0;
               end
               if (chord_mode_ff == MODE_EITHER && !pp && !mp) begin
                  sel_lvl = 17'sd0;
               end
               if (chord_mode_ff == MODE_ONE && pp == mp) begin
                  sel_lvl = 17'sd0;
               end
               sel_chg = 18'(sel_lvl) - 18'(cl);
            end
            MODE_NEITHER: begin
               sel_lvl = -17'(mn);
               if (pp || mp) begin
                  sel_lvl = 17'sd0;
               end
               sel_chg = 18'(sel_lvl) - 18'(cl);
            end
            MODE_GATE: begin
               if (!mp) begin
                  sel_lvl = 17'sd0;
                  sel_chg = -18'(cl);
               end else if (mod_nx.flags[FLAG_TRIGGERED] && pp &&
                            !pri_nx.flags[FLAG_TRIGGERED]) begin
                  latch_nx = 1'b1;
                  sel_lvl  = 17'sd0;
                  sel_chg  = 18'sd0;
               end else begin
                  sel_lvl = 17'(p);
                  sel_chg = 18'(pri_nx.change);
               end
            end
            default: begin
               if (mp) begin
                  sel_lvl = 17'sd0;
                  sel_chg = -18'(cl);
               end else begin
                  sel_lvl = 17'(p);
                  sel_chg = 18'(p) - 18'(cl);
               end
            end
         endcase
      end
   end

   // Repeat delay on the combined unit.
   always_comb begin
      lvl_s  = sat16(18'(sel_lvl));
      lvl_r  = lvl_s;
      chg_r  = sel_chg;
      rem_nx = repeat_remaining_ff;
      if (repeat_delay_ff != 16'd0) begin
         if (lvl_s > -HALF_Q && lvl_s < HALF_Q) begin
            rem_nx = repeat_delay_ff;
         end else if (repeat_remaining_ff != 16'd0) begin
            rem_nx = (repeat_remaining_ff > {6'd0, el_ff}) ?
                     repeat_remaining_ff - {6'd0, el_ff} : 16'd0;
            if (rem_nx != 16'd0) begin
               lvl_r = 16'sd0;
            end
            chg_r = 18'(lvl_r) - 18'(cl);
         end
      end
   end

   abcq_unit u_cmb (
      .el         (el_ff),
      .lvl        (lvl_r),
      .chg        (chg_r),
      .tap_window (tap_window_ff),
      .cur        (cmb_ff),
      .nxt        (cmb_nx)
   );

   always_comb begin
      in_valid_in         = in_valid_ff;
      rsp_valid_in        = rsp_valid_ff;
      chord_mode_in       = chord_mode_ff;
      repeat_delay_in     = repeat_delay_ff;
      tap_window_in       = tap_window_ff;
      repeat_remaining_in = repeat_remaining_ff;
      gate_latch_in       = gate_latch_ff;
      pri_in              = pri_ff;
      mod_in              = mod_ff;
      cmb_in              = cmb_ff;

      if (req_ready) begin
         in_valid_in = req_valid;
      end
      if (adv) begin
         rsp_valid_in = in_valid_ff;
      end
      if (step) begin
         pri_in              = pri_nx;
         cmb_in              = cmb_nx;
         repeat_remaining_in = rem_nx;
         gate_latch_in       = latch_nx;
         if (mod_upd) begin
            mod_in = mod_nx;
         end
      end
      if (csr_write) begin
         case (csr_index)
            CSR_CHORD_MODE: begin
               // A new chord mode starts the combined unit afresh; flags stay.
               chord_mode_in       = csr_data[2:0];
               cmb_in.level        = 16'sd0;
               cmb_in.change       = 16'sd0;
               cmb_in.hold         = 16'd0;
               cmb_in.gap          = 16'd0;
               cmb_in.taps         = 8'd0;
               repeat_remaining_in = repeat_delay_ff;
            end
            CSR_REPEAT_DELAY: begin
               repeat_delay_in     = csr_data;
               repeat_remaining_in = csr_data;
            end
            CSR_TAP_WINDOW: begin
               tap_window_in = csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff         <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         chord_mode_ff       <= RESET_CHORD_MODE;
         repeat_delay_ff     <= RESET_REPEAT_DELAY;
         tap_window_ff       <= RESET_TAP_WINDOW;
         repeat_remaining_ff <= RESET_REPEAT_DELAY;
         gate_latch_ff       <= 1'b0;
         pri_ff              <= '0;
         mod_ff              <= '0;
         cmb_ff              <= '0;
      end else begin
         in_valid_ff         <= in_valid_in;
         rsp_valid_ff        <= rsp_valid_in;
         chord_mode_ff       <= chord_mode_in;
         repeat_delay_ff     <= repeat_delay_in;
         tap_window_ff       <= tap_window_in;
         repeat_remaining_ff <= repeat_remaining_in;
         gate_latch_ff       <= gate_latch_in;
         pri_ff              <= pri_in;
         mod_ff              <= mod_in;
         cmb_ff              <= cmb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         el_ff <= req_elapsed_ms;
         pl_ff <= req_primary_level;
         pc_ff <= req_primary_change;
         ml_ff <= req_modifier_level;
         mc_ff <= req_modifier_change;
      end
      if (step) begin
         rsp_level_ff  <= cmb_nx.level;
         rsp_change_ff <= cmb_nx.change;
         rsp_flags_ff  <= cmb_nx.flags;
         rsp_hold_ff   <= cmb_nx.hold;
         rsp_taps_ff   <= cmb_nx.taps;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_level         = rsp_level_ff;
   assign rsp_change        = rsp_change_ff;
   assign rsp_pressed       = rsp_flags_ff[FLAG_PRESSED];
   assign rsp_triggered     = rsp_flags_ff[FLAG_TRIGGERED];
   assign rsp_released      = rsp_flags_ff[FLAG_RELEASED];
   assign rsp_quick_release = rsp_flags_ff[FLAG_QUICK];
   assign rsp_hold_ms       = rsp_hold_ff;
   assign rsp_tap_count     = rsp_taps_ff;

   `ABCQ_NEVER(a_rem_within_delay, clock, reset, repeat_remaining_ff > repeat_delay_ff)
   `ABCQ_ASSERT(a_latch_only_in_gate, clock, reset, gate_latch_ff && !$past(gate_latch_ff) |-> $past(chord_mode_ff) == MODE_GATE)
   `ABCQ_ASSERT(a_pressed_matches_level, clock, reset, rsp_valid_ff |-> rsp_flags_ff[FLAG_PRESSED] == (rsp_level_ff >= HALF_Q || rsp_level_ff <= -HALF_Q))
   `ABCQ_ASSERT(a_input_held_on_stall, clock, reset, in_valid_ff && !adv |=> in_valid_ff)

endmodule
